FILE: design/murmur2_string_hash_core_assert.svh
// assertion macros shared by the hash core modules
// expects clk and rst_n in the scope of use
`ifndef MURMUR2_STRING_HASH_CORE_ASSERT_SVH
`define MURMUR2_STRING_HASH_CORE_ASSERT_SVH

// same-cycle implication
`define M2SH_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m2sh assertion failed");

// next-cycle implication
`define M2SH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m2sh assertion failed");

`endif

FILE: design/m2sh_pkg.sv
// types, constants and codes for the murmur2 string hash core
// no dependencies
package m2sh_pkg;

    localparam logic [31:0] MIX_M   = 32'h5db1e995;
    localparam int          MIX_R   = 24;
    localparam int          FIN_R1  = 13;
    localparam int          FIN_R2  = 15;

    localparam int          WORD_W  = 32;
    localparam int          COUNT_W = 3;

    localparam int          QUEUE_DEPTH = 2;
    localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TAIL,
        OP_FULL
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H,
        ST_TAIL,
        ST_FIN1,
        ST_FIN2
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] start;
        logic              first;
        logic              last;
    } item_t;

endpackage

FILE: design/m2sh_in_if.sv
// input channel: one string word per beat
// depends on m2sh_pkg
interface m2sh_in_if;
    import m2sh_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic [WORD_W-1:0]  total_length;
    logic               first_item;
    logic               last_item;

    modport source (
        output valid, data_word, byte_count, total_length, first_item, last_item,
        input  ready
    );

    modport sink (
        input  valid, data_word, byte_count, total_length, first_item, last_item,
        output ready
    );
endinterface

FILE: design/m2sh_out_if.sv
// output channel: one hash per beat
// depends on m2sh_pkg
interface m2sh_out_if;
    import m2sh_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );

    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

FILE: design/m2sh_front.sv
// front end: seed register, beat acceptance and classification
// depends on m2sh_pkg and m2sh_in_if
module m2sh_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [m2sh_pkg::WORD_W-1:0] cfg_wr_data,
    m2sh_in_if.sink                   in_ch,
    input  logic                      q_full,
    output logic                      push,
    output m2sh_pkg::item_t           push_item
);
    import m2sh_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] seed_next;

    always_comb
    begin
        seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        push_item.start = seed_reg ^ in_ch.total_length;
        push_item.first = in_ch.first_item;
        push_item.last  = in_ch.last_item;
        case (in_ch.byte_count) inside
            [3'd4:3'd7]:
            begin
                push_item.op   = OP_FULL;
                push_item.word = in_ch.data_word;
            end
            3'd3:
            begin
                push_item.op   = OP_TAIL;
                push_item.word = {8'h00, in_ch.data_word[23:0]};
            end
            3'd2:
            begin
                push_item.op   = OP_TAIL;
                push_item.word = {16'h0000, in_ch.data_word[15:0]};
            end
            3'd1:
            begin
                push_item.op   = OP_TAIL;
                push_item.word = {24'h000000, in_ch.data_word[7:0]};
            end
            default:
            begin
                push_item.op   = OP_NONE;
                push_item.word = '0;
            end
        endcase
    end
endmodule

FILE: design/m2sh_queue.sv
// two-entry queue between front and back ends
// depends on m2sh_pkg
`include "murmur2_string_hash_core_assert.svh"
module m2sh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  m2sh_pkg::item_t push_item,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output m2sh_pkg::item_t pop_item
);
    import m2sh_pkg::*;

    item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                pop;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `M2SH_ASSERT_IMPL(a_no_overflow, push, count_reg != QUEUE_CW'(QUEUE_DEPTH))
    `M2SH_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= QUEUE_CW'(QUEUE_DEPTH))
    `M2SH_ASSERT_NEXT(a_push_pop_keeps_count, push && pop, $stable(count_reg))
endmodule

FILE: design/m2sh_back.sv
// back end: mixing sequencer around one shared multiplier, output register
// depends on m2sh_pkg and m2sh_out_if
`include "murmur2_string_hash_core_assert.svh"
module m2sh_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  m2sh_pkg::item_t pop_item,
    m2sh_out_if.source      out_ch
);
    import m2sh_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] h_reg;
    logic [WORD_W-1:0] h_next;
    logic [WORD_W-1:0] w_reg;
    logic [WORD_W-1:0] w_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] prod_next;
    logic              last_reg;
    logic              last_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_data_reg;
    logic [WORD_W-1:0] out_data_next;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_lo;
    logic [WORD_W-1:0] h_in;
    logic              out_load;

    // low word of the product only
    assign mul_lo = mul_a * MIX_M;

    assign out_load = !out_valid_reg || out_ch.ready;
    assign h_in     = pop_item.first ? pop_item.start : h_reg;

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        mul_a          = h_reg;
        pop_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    last_next = pop_item.last;
                    w_next    = pop_item.word;
                    case (pop_item.op)
                        OP_FULL:
                        begin
                            h_next     = h_in;
                            state_next = ST_K1;
                        end
                        OP_TAIL:
                        begin
                            h_next     = h_in ^ pop_item.word;
                            state_next = ST_TAIL;
                        end
                        default:
                        begin
                            h_next     = h_in;
                            state_next = pop_item.last ? ST_FIN1 : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_K1:
            begin
                mul_a      = w_reg;
                prod_next  = mul_lo;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                mul_a      = prod_reg ^ (prod_reg >> MIX_R);
                prod_next  = mul_lo;
                state_next = ST_H;
            end
            ST_H:
            begin
                mul_a      = h_reg;
                h_next     = mul_lo ^ prod_reg;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_TAIL:
            begin
                mul_a      = h_reg;
                h_next     = mul_lo;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                mul_a      = h_reg ^ (h_reg >> FIN_R1);
                prod_next  = mul_lo;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = prod_reg ^ (prod_reg >> FIN_R2);
                    h_next         = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hash_value = out_data_reg;

    `M2SH_ASSERT_NEXT(a_fin_clears_hash, state_reg == ST_FIN2 && out_load, h_reg == '0)
    `M2SH_ASSERT_IMPL(a_h_after_k2, state_reg == ST_H, $past(state_reg) == ST_K2)
    `M2SH_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN2)
endmodule

FILE: design/murmur2_string_hash_core.sv
// murmur2-style 32-bit string hash core with mixing constant 32'h5db1e995: a full word passes
// through K1, K2 and H, a tail word through TAIL, both using the one shared 32x32 multiplier;
// an empty word needs no multiply; the last word adds the finalize states FIN1 and FIN2
// a two-entry queue lets the front accept beats while the back is mixing
// reset clears the seed, the running hash and the output valid flag, and empties the queue
module murmur2_string_hash_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [m2sh_pkg::WORD_W-1:0] cfg_wr_data,
    m2sh_in_if.sink                     in_ch,
    m2sh_out_if.source                  out_ch
);
    import m2sh_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    m2sh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    m2sh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    m2sh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_ch    (out_ch)
    );
endmodule
